### hw/rtl/rmv_pkg.sv
package rmv_pkg;

  // Number formats
  localparam int COUNT_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int SAMPLE_W   = 16;
  localparam int MEAN_W     = 32;
  localparam int VAR_W      = 47;
  localparam int CNT_OUT_W  = 16;
  localparam int M2_W       = 63;

  // Deviation magnitudes and the split product
  localparam int MAG_W   = MEAN_W + 1;
  localparam int LO_W    = MAG_W / 2;
  localparam int HI_W    = MAG_W - LO_W;
  localparam int PPROD_W = MAG_W + HI_W;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int TERM_W  = PROD_W - FRAC_BITS;

  // Serial divider
  localparam int DVD_W  = M2_W;
  localparam int STEP_W = $clog2(DVD_W + 1);

  typedef logic [COUNT_BITS-1:0] count_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic delta;
    logic div_mean;
    logic mean_upd;
    logic delta2;
    logic mag;
    logic mul_lo;
    logic mul_hi;
    logic acc_add;
    logic m2_upd;
    logic div_var;
    logic out_load;
    logic var_zero;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic last;
    logic multi;
    logic out_free;
  } dp_stat_t;

endpackage

### hw/rtl/running_mean_variance.sv
// Running mean and sample variance (Welford update) over runs of signed samples.
// Input channel: in_sample with in_last marking the final sample of a run;
// a request is taken when in_valid is high and in_stall is low.
// Output channel: one result per run, after the last sample: out_mean_value
// (signed, 16 fraction bits), out_variance_value (M2/(n-1), 16 fraction bits,
// zero for a single-sample run), out_sample_count and out_overflow.
// in_stall stays high after each accepted sample until its update is done, so
// no new sample goes in before the last one is through; the serial divider
// (one quotient bit per cycle, 33 bits for delta/n) takes most of that time.
// A last sample of a multi-sample run adds the variance division, 63 more bits.
// The result sits in an output register; the block keeps taking samples of
// the next run while a result waits under out_stall, and holds only when a
// second result is ready before the first has been taken.
// Count saturates at 65535 and sets the overflow flag for that run.
// Synchronous active-low reset clears the count, mean, M2, the overflow flag
// and the output valid; all run state also clears after each result.
module running_mean_variance (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rmv_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rmv_pkg::MEAN_W-1:0]   out_mean_value,
  output logic [rmv_pkg::VAR_W-1:0]           out_variance_value,
  output logic [rmv_pkg::CNT_OUT_W-1:0]       out_sample_count,
  output logic                                out_overflow
);

  rmv_pkg::dp_cmd_t  cmd;
  rmv_pkg::dp_stat_t stat;

  rmv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rmv_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_sample          (in_sample),
    .in_last            (in_last),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_mean_value     (out_mean_value),
    .out_variance_value (out_variance_value),
    .out_sample_count   (out_sample_count),
    .out_overflow       (out_overflow)
  );

endmodule

### hw/rtl/rmv_div.sv
module rmv_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rmv_pkg::DVD_W-1:0]    dividend,
  input  rmv_pkg::count_t              divisor,
  input  logic [rmv_pkg::STEP_W-1:0]   steps,
  output logic [rmv_pkg::DVD_W-1:0]    quotient,
  output logic                         done
);

  logic [rmv_pkg::DVD_W-1:0]      quo_r;
  logic [rmv_pkg::COUNT_BITS-1:0] rem_r;
  rmv_pkg::count_t                div_r;
  logic [rmv_pkg::STEP_W-1:0]     cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [rmv_pkg::COUNT_BITS:0]   trial;
  logic [rmv_pkg::COUNT_BITS:0]   diff;
  logic                           ge;

  // One restoring step: bring in the next dividend bit, try the subtract
  always_comb begin
    trial = {rem_r, quo_r[rmv_pkg::DVD_W-1]};
    diff  = trial - {1'b0, div_r};
    ge    = (trial >= {1'b0, div_r});
  end

  // Dividend is left-aligned; quotient bits collect at the low end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
        quo_r  <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[rmv_pkg::DVD_W-2:0], ge};
        rem_r <= ge ? diff[rmv_pkg::COUNT_BITS-1:0] : trial[rmv_pkg::COUNT_BITS-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == rmv_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

### hw/rtl/rmv_dp.sv
module rmv_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [rmv_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_last,
  input  rmv_pkg::dp_cmd_t                    cmd,
  output rmv_pkg::dp_stat_t                   stat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rmv_pkg::MEAN_W-1:0]   out_mean_value,
  output logic [rmv_pkg::VAR_W-1:0]           out_variance_value,
  output logic [rmv_pkg::CNT_OUT_W-1:0]       out_sample_count,
  output logic                                out_overflow
);

  localparam int MW = rmv_pkg::MEAN_W;
  localparam int AW = rmv_pkg::MAG_W;

  // Running state
  rmv_pkg::count_t           count_r;
  logic                      ovf_r;
  logic [MW-1:0]             mean_r;
  logic [rmv_pkg::M2_W-1:0]  m2_r;

  // Per-request working registers
  logic [MW-1:0]                 xf_r;
  logic                          last_r;
  logic [AW-1:0]                 delta_r;
  logic [AW-1:0]                 delta2_r;
  logic [AW-1:0]                 mag_a_r;
  logic [AW-1:0]                 mag_b_r;
  logic [rmv_pkg::PPROD_W-1:0]   prod_r;
  logic [rmv_pkg::PROD_W-1:0]    acc_r;

  // Result register
  logic                          out_valid_r;
  logic [MW-1:0]                 out_mean_r;
  logic [rmv_pkg::VAR_W-1:0]     out_var_r;
  logic [rmv_pkg::CNT_OUT_W-1:0] out_cnt_r;
  logic                          out_ovf_r;

  logic [MW-1:0]                 sample_ext;
  logic [MW-1:0]                 xf;
  logic [AW-1:0]                 delta_calc;
  logic [AW-1:0]                 delta2_calc;
  logic [AW-1:0]                 mag_a;
  logic [AW-1:0]                 mag_b;
  logic [AW-1:0]                 quo_mag;
  logic [AW-1:0]                 mean_plus;
  logic [AW-1:0]                 mean_minus;
  logic [rmv_pkg::HI_W-1:0]      mul_op;
  logic [rmv_pkg::PPROD_W-1:0]   pp;
  logic [rmv_pkg::TERM_W-1:0]    term;
  logic [rmv_pkg::M2_W:0]        term_ext;
  logic [rmv_pkg::M2_W:0]        m2_sum;
  logic [rmv_pkg::M2_W:0]        m2_diff;
  logic                          neg;
  logic [rmv_pkg::M2_W-1:0]      m2_nxt;
  logic [rmv_pkg::VAR_W-1:0]     var_sat;
  logic                          count_full;

  logic                          div_start;
  logic [rmv_pkg::DVD_W-1:0]     div_dividend;
  rmv_pkg::count_t               div_divisor;
  logic [rmv_pkg::STEP_W-1:0]    div_steps;
  logic [rmv_pkg::DVD_W-1:0]     div_quo;
  logic                          div_done;

  // Sample to fixed point, deviations and magnitudes
  always_comb begin
    sample_ext  = {{(MW-rmv_pkg::SAMPLE_W){in_sample[rmv_pkg::SAMPLE_W-1]}}, in_sample};
    xf          = sample_ext << rmv_pkg::FRAC_BITS;
    delta_calc  = {xf_r[MW-1], xf_r} - {mean_r[MW-1], mean_r};
    delta2_calc = delta_calc;
    mag_a       = delta_r[AW-1] ? (AW'(0) - delta_r) : delta_r;
    mag_b       = delta2_r[AW-1] ? (AW'(0) - delta2_r) : delta2_r;
    count_full  = (count_r == '1);
  end

  // Mean step: mean += delta / n, quotient truncated toward zero
  always_comb begin
    quo_mag    = div_quo[AW-1:0];
    mean_plus  = {mean_r[MW-1], mean_r} + quo_mag;
    mean_minus = {mean_r[MW-1], mean_r} - quo_mag;
  end

  // Two-part product of the magnitudes, one partial product per cycle
  always_comb begin
    mul_op = cmd.mul_hi ? mag_b_r[AW-1:rmv_pkg::LO_W]
                        : rmv_pkg::HI_W'(mag_b_r[rmv_pkg::LO_W-1:0]);
    pp     = mag_a_r * mul_op;
  end

  // M2 accumulate with saturation at both ends
  always_comb begin
    term     = acc_r[rmv_pkg::PROD_W-1:rmv_pkg::FRAC_BITS];
    term_ext = (rmv_pkg::M2_W + 1)'(term);
    m2_sum   = {1'b0, m2_r} + term_ext;
    m2_diff  = {1'b0, m2_r} - term_ext;
    neg      = delta_r[AW-1] != delta2_r[AW-1];
    if (neg) begin
      m2_nxt = m2_diff[rmv_pkg::M2_W] ? '0 : m2_diff[rmv_pkg::M2_W-1:0];
    end else begin
      m2_nxt = m2_sum[rmv_pkg::M2_W] ? '1 : m2_sum[rmv_pkg::M2_W-1:0];
    end
  end

  // Variance clamp
  always_comb begin
    if (div_quo[rmv_pkg::DVD_W-1:rmv_pkg::VAR_W] != '0) begin
      var_sat = '1;
    end else begin
      var_sat = div_quo[rmv_pkg::VAR_W-1:0];
    end
  end

  // Shared divider: delta / n per sample, M2 / (n-1) at end of run
  always_comb begin
    div_start = cmd.div_mean | cmd.div_var;
    if (cmd.div_var) begin
      div_dividend = m2_r;
      div_divisor  = count_r - 1'b1;
      div_steps    = rmv_pkg::STEP_W'(rmv_pkg::DVD_W);
    end else begin
      div_dividend = rmv_pkg::DVD_W'(mag_a) << (rmv_pkg::DVD_W - AW);
      div_divisor  = count_r;
      div_steps    = rmv_pkg::STEP_W'(AW);
    end
  end

  rmv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .quotient (div_quo),
    .done     (div_done)
  );

  // Running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      mean_r  <= '0;
      m2_r    <= '0;
    end else if (cmd.out_load) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      mean_r  <= '0;
      m2_r    <= '0;
    end else begin
      if (cmd.load) begin
        if (count_full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + 1'b1;
        end
      end
      if (cmd.mean_upd) begin
        mean_r <= delta_r[AW-1] ? mean_minus[MW-1:0] : mean_plus[MW-1:0];
      end
      if (cmd.m2_upd) begin
        m2_r <= m2_nxt;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xf_r   <= xf;
      last_r <= in_last;
    end
    if (cmd.delta) begin
      delta_r <= delta_calc;
    end
    if (cmd.div_mean) begin
      mag_a_r <= mag_a;
    end
    if (cmd.delta2) begin
      delta2_r <= delta2_calc;
    end
    if (cmd.mag) begin
      mag_b_r <= mag_b;
    end
    if (cmd.mul_lo || cmd.mul_hi) begin
      prod_r <= pp;
    end
    if (cmd.mul_hi) begin
      acc_r <= rmv_pkg::PROD_W'(prod_r);
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + (rmv_pkg::PROD_W'(prod_r) << rmv_pkg::LO_W);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_mean_r <= mean_r;
      out_var_r  <= cmd.var_zero ? '0 : var_sat;
      out_cnt_r  <= rmv_pkg::CNT_OUT_W'(count_r);
      out_ovf_r  <= ovf_r;
    end
  end

  always_comb begin
    stat.div_done = div_done;
    stat.last     = last_r;
    stat.multi    = (count_r >= rmv_pkg::COUNT_BITS'(2));
    stat.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid          = out_valid_r;
  assign out_mean_value     = out_mean_r;
  assign out_variance_value = out_var_r;
  assign out_sample_count   = out_cnt_r;
  assign out_overflow       = out_ovf_r;

endmodule

### hw/rtl/rmv_ctrl.sv
module rmv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rmv_pkg::dp_stat_t  stat,
  output rmv_pkg::dp_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DELTA,
    S_DIVM,
    S_WAITM,
    S_MEAN,
    S_DELTA2,
    S_MAG,
    S_MUL_LO,
    S_MUL_HI,
    S_ACC,
    S_M2,
    S_DIVV,
    S_WAITV,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and per-state datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DELTA;
        end
      end
      S_DELTA: begin
        cmd.delta = 1'b1;
        state_nxt = S_DIVM;
      end
      S_DIVM: begin
        cmd.div_mean = 1'b1;
        state_nxt    = S_WAITM;
      end
      S_WAITM: begin
        if (stat.div_done) begin
          state_nxt = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd.mean_upd = 1'b1;
        state_nxt    = S_DELTA2;
      end
      S_DELTA2: begin
        cmd.delta2 = 1'b1;
        state_nxt  = S_MAG;
      end
      S_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_M2;
      end
      S_M2: begin
        cmd.m2_upd = 1'b1;
        if (!stat.last) begin
          state_nxt = S_IDLE;
        end else if (stat.multi) begin
          state_nxt = S_DIVV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIVV: begin
        cmd.div_var = 1'b1;
        state_nxt   = S_WAITV;
      end
      S_WAITV: begin
        if (stat.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.var_zero = !stat.multi;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

### dv/tb_running_mean_variance.sv
`timescale 1ns / 1ps

module tb_running_mean_variance;

  // Saturation bounds of the running statistics
  localparam longint unsigned COUNT_LIMIT = (64'd1 << rmv_pkg::COUNT_BITS) - 1;
  localparam bit [63:0] M2_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam bit [63:0] VAR_LIMIT = (64'd1 << rmv_pkg::VAR_W) - 1;

  localparam logic signed [rmv_pkg::SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [rmv_pkg::SAMPLE_W-1:0] S_MIN = 16'sh8000;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int PHASE_REQUESTS = 340;
  localparam int DRAIN_CYCLES = 150;

  // Welford tracker: folds each accepted sample and queues the stats of each finished run
  class welford_scoreboard;
    typedef struct packed {
      logic signed [rmv_pkg::MEAN_W-1:0] mean;
      logic [rmv_pkg::VAR_W-1:0]         variance;
      logic [rmv_pkg::CNT_OUT_W-1:0]     count;
      logic                              ovf;
    } run_stats_t;

    longint unsigned run_count;
    longint          run_mean;
    bit [63:0]       run_m2;
    bit              run_ovf;
    run_stats_t      stats_due[$];
    int unsigned     mismatches;

    function void clear_run();
      run_count = 0;
      run_mean  = 0;
      run_m2    = 0;
      run_ovf   = 1'b0;
    endfunction

    function new();
      clear_run();
      mismatches = 0;
    endfunction

    function int pending();
      return stats_due.size();
    endfunction

    function void note_sample(logic signed [rmv_pkg::SAMPLE_W-1:0] sample, logic is_last);
      longint     xf;
      longint     delta;
      longint     delta2;
      bit [63:0]  mag_a;
      bit [63:0]  mag_b;
      bit [127:0] prod;
      bit [63:0]  term;
      bit [63:0]  var_q;
      run_stats_t s;

      xf = longint'(sample) * (longint'(1) << rmv_pkg::FRAC_BITS);

      // count saturates; a sample past the limit flags the run
      if (run_count >= COUNT_LIMIT) begin
        run_count = COUNT_LIMIT;
        run_ovf   = 1'b1;
      end else begin
        run_count++;
      end

      delta    = xf - run_mean;
      run_mean = run_mean + delta / longint'(run_count);
      delta2   = xf - run_mean;

      // product of magnitudes, fraction trimmed, then signed accumulate into M2
      mag_a = (delta < 0) ? -delta : delta;
      mag_b = (delta2 < 0) ? -delta2 : delta2;
      prod  = mag_a * mag_b;
      term  = prod >> rmv_pkg::FRAC_BITS;
      if ((delta < 0) != (delta2 < 0)) begin
        run_m2 = (term >= run_m2) ? 64'd0 : run_m2 - term;
      end else begin
        run_m2 = (term > M2_LIMIT - run_m2) ? M2_LIMIT : run_m2 + term;
      end

      if (!is_last) return;

      var_q = 0;
      if (run_count >= 2) begin
        var_q = run_m2 / (run_count - 1);
        if (var_q > VAR_LIMIT) var_q = VAR_LIMIT;
      end
      s.mean     = run_mean[rmv_pkg::MEAN_W-1:0];
      s.variance = var_q[rmv_pkg::VAR_W-1:0];
      s.count    = run_count[rmv_pkg::CNT_OUT_W-1:0];
      s.ovf      = run_ovf;
      stats_due  = {stats_due, s};
      clear_run();
    endfunction

    function void compare_field(string field, logic [63:0] expected, logic [63:0] actual);
      if (expected !== actual) begin
        mismatches++;
        $display("%0t: %s expected 'h%0h, actual 'h%0h", $time, field, expected, actual);
      end
    endfunction

    function void check_stats(logic signed [rmv_pkg::MEAN_W-1:0] mean,
                              logic [rmv_pkg::VAR_W-1:0] variance,
                              logic [rmv_pkg::CNT_OUT_W-1:0] count, logic ovf);
      run_stats_t s;
      if (stats_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual mean 'h%0h count %0d",
                 $time, mean, count);
        return;
      end
      s = stats_due.pop_front();
      compare_field("mean_value", s.mean, mean);
      compare_field("variance_value", s.variance, variance);
      compare_field("sample_count", s.count, count);
      compare_field("overflow", s.ovf, ovf);
    endfunction
  endclass

  logic                                clk;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [rmv_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic                                in_last = 1'b0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [rmv_pkg::MEAN_W-1:0]   out_mean_value;
  logic [rmv_pkg::VAR_W-1:0]           out_variance_value;
  logic [rmv_pkg::CNT_OUT_W-1:0]       out_sample_count;
  logic                                out_overflow;

  welford_scoreboard sb = new();

  int idle_pct = 0;
  int stall_pct = 0;
  int requests_sent = 0;
  int stall_burst = 0;
  int cycle_count = 0;

  running_mean_variance uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_mean_value     (out_mean_value),
    .out_variance_value (out_variance_value),
    .out_sample_count   (out_sample_count),
    .out_overflow       (out_overflow)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: check accepted results, then pick the next stall value
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_stats(out_mean_value, out_variance_value, out_sample_count, out_overflow);
    if (stall_burst > 0) begin
      stall_burst = stall_burst - 1;
      out_stall <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(1023) == 0) begin
      // long hold so a second result backs up behind the first
      stall_burst = $urandom_range(40, 120);
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // One request, with an optional idle gap ahead of it
  task automatic send_sample(input logic signed [rmv_pkg::SAMPLE_W-1:0] value,
                             input logic is_last);
    int gap;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct)
      gap = ($urandom_range(7) == 0) ? $urandom_range(40, 130) : $urandom_range(1, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    in_last   <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(value, is_last);
    requests_sent++;
  endtask

  // Mix of extremes, small values, values clustered near a run level, and full range
  function automatic logic signed [rmv_pkg::SAMPLE_W-1:0] pick_sample(
      input logic signed [rmv_pkg::SAMPLE_W-1:0] level);
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return S_MIN;
          1: return S_MAX;
          2: return '0;
          3: return '1;
          default: return 16'sd1;
        endcase
      end
      1, 2: return rmv_pkg::SAMPLE_W'($urandom_range(32)) - 16'd16;
      3, 4: return level + rmv_pkg::SAMPLE_W'($urandom_range(15)) - 16'd8;
      default: return rmv_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // Random run: mostly short, now and then a longer one
  task automatic send_random_run();
    int len;
    logic signed [rmv_pkg::SAMPLE_W-1:0] level;
    len = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
    level = rmv_pkg::SAMPLE_W'($urandom);
    for (int i = 0; i < len; i++)
      send_sample(pick_sample(level), i == len - 1);
  endtask

  // Directed runs: single extremes, widest spread, alternating extremes,
  // constant run (zero variance), small mixed values for truncation effects
  logic signed [rmv_pkg::SAMPLE_W-1:0] directed_samples [22] = '{
    S_MAX, S_MIN, 16'sd0,
    S_MIN, S_MAX,
    S_MAX, S_MIN,
    S_MAX, S_MIN, S_MAX, S_MIN,
    -16'sd1, -16'sd1, -16'sd1,
    16'sd3, -16'sd2, 16'sd7, 16'sd0, -16'sd5,
    16'sd1, 16'sd2, 16'sd2
  };
  bit directed_last [22] = '{
    1, 1, 1,
    0, 1,
    0, 1,
    0, 0, 0, 1,
    0, 0, 1,
    0, 0, 0, 0, 1,
    0, 0, 1
  };

  int phase_idle [5] = '{0, 46, 0, 8, 0};
  int phase_stall [5] = '{0, 0, 46, 8, 0};

  initial begin
    int quota;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_samples[i])
      send_sample(directed_samples[i], directed_last[i]);

    // Random runs under each idling mix
    for (int p = 0; p < 5; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      quota = requests_sent + PHASE_REQUESTS;
      while (requests_sent < quota) send_random_run();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
hw/rtl/rmv_pkg.sv
hw/rtl/rmv_div.sv
hw/rtl/rmv_dp.sv
hw/rtl/rmv_ctrl.sv
hw/rtl/running_mean_variance.sv
dv/tb_running_mean_variance.sv
